### design/ols_pkg.sv
// Shared types, constants and helpers for the octilinear line snap block.
// No dependencies; imported by design/octilinear_line_snap.sv.
package ols_pkg;

    // Coordinates and differences.
    typedef logic signed [30:0] coord_t;
    typedef logic signed [31:0] delta_t;
    typedef logic        [31:0] dmag_t;
    typedef logic signed [32:0] slope_num_t;
    typedef logic signed [50:0] cmp_t;
    typedef logic        [2:0]  dir_t;
    typedef logic        [1:0]  route_mode_t;

    // Route mode register codes; the unused code behaves as free mode.
    localparam route_mode_t MODE_FREE  = 2'd0;
    localparam route_mode_t MODE_SNAP  = 2'd1;
    localparam route_mode_t MODE_BEND  = 2'd2;
    localparam route_mode_t MODE_RESET = MODE_SNAP;

    // Register map: byte address index of each register.
    localparam int          ADDR_W         = 3;
    localparam logic        REG_ROUTE_MODE = 1'b0;

    // Sector borders in Q16: tan 30 (truncated) and tan 60 (rounded).
    localparam logic [16:0] TAN30_Q16 = 17'd37837;
    localparam logic [16:0] TAN60_Q16 = 17'd113512;

    // The eight snap directions, counted clockwise from straight +y.
    localparam dir_t DIR_POS_Y     = 3'd0;
    localparam dir_t DIR_POS_XY    = 3'd1;
    localparam dir_t DIR_POS_X     = 3'd2;
    localparam dir_t DIR_POS_X_NEG = 3'd3;
    localparam dir_t DIR_NEG_Y     = 3'd4;
    localparam dir_t DIR_NEG_XY    = 3'd5;
    localparam dir_t DIR_NEG_X     = 3'd6;
    localparam dir_t DIR_NEG_X_POS = 3'd7;
    localparam dir_t DIR_HALF_TURN = 3'd4;

    // Input stage contents.
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t cx;
        coord_t cy;
        logic   anchored;
        logic   hide;
        logic   way;
    } in_stage_t;

    // Difference stage contents.
    typedef struct packed {
        coord_t     ax;
        coord_t     ay;
        coord_t     cx;
        coord_t     cy;
        dmag_t      adx;
        dmag_t      ady;
        slope_num_t sdy;
        logic       dx_neg;
        logic       dx_zero;
        logic       dy_pos;
        logic       dy_neg;
        logic       live;
        logic       zero_len;
        logic       way;
    } diff_stage_t;

    // Moves a coordinate by a magnitude; the 31-bit wrap matches the output field.
    function automatic coord_t coord_step(coord_t base, dmag_t amount, logic neg);
        coord_t res;
        if (neg)
        begin
            res = base - coord_t'(amount[30:0]);
        end
        else
        begin
            res = base + coord_t'(amount[30:0]);
        end
        return res;
    endfunction

endpackage

### design/octilinear_line_snap.sv
// Octilinear line snap: free, 45-degree snap and two-segment bend of a drawn line.
// Depends on ols_pkg (design/ols_pkg.sv).
// Throughput: one transaction per cycle while out_stall is low;
// the Q16 sector compares sit between the difference and result stages.
// Three registered stages (input, difference, result) each load whenever the next moves.
// Reset clears all stage valid flags and sets route_mode to single 45-degree snap.
module octilinear_line_snap (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ols_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ols_pkg::coord_t            anchor_x,
    input  ols_pkg::coord_t            anchor_y,
    input  ols_pkg::coord_t            cursor_x,
    input  ols_pkg::coord_t            cursor_y,
    input  logic                       anchored,
    input  logic                       hide,
    input  logic                       way,
    // Output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output ols_pkg::coord_t            end_x,
    output ols_pkg::coord_t            end_y,
    output logic                       draw,
    output logic                       changed
);
    import ols_pkg::*;

    route_mode_t route_mode_reg;

    logic        in_valid_reg;
    in_stage_t   in_reg;
    logic        diff_valid_reg;
    diff_stage_t diff_reg;
    diff_stage_t diff_next;
    logic        out_valid_reg;
    coord_t      end_x_reg;
    coord_t      end_y_reg;
    logic        draw_reg;
    logic        changed_reg;
    coord_t      end_x_next;
    coord_t      end_y_next;
    logic        draw_next;
    logic        changed_next;

    logic        out_ready;
    logic        diff_ready;
    logic        in_ready;
    logic        cfg_write;

    // Configuration register: written on the access phase, read back as stored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ROUTE_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_mode_reg <= MODE_RESET;
        end
        else if (cfg_write)
        begin
            route_mode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ROUTE_MODE)
        begin
            prdata = {30'd0, route_mode_reg};
        end
    end

    // Each stage loads when it is empty or when its contents move on.
    assign out_ready  = !out_valid_reg || !out_stall;
    assign diff_ready = !diff_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || diff_ready;
    assign in_stall   = !in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg.ax       <= anchor_x;
            in_reg.ay       <= anchor_y;
            in_reg.cx       <= cursor_x;
            in_reg.cy       <= cursor_y;
            in_reg.anchored <= anchored;
            in_reg.hide     <= hide;
            in_reg.way      <= way;
        end
    end

    // Differences, their magnitudes and the sign-folded slope numerator.
    always_comb
    begin
        delta_t dx;
        delta_t dy;
        dx = delta_t'(in_reg.cx) - delta_t'(in_reg.ax);
        dy = delta_t'(in_reg.cy) - delta_t'(in_reg.ay);
        diff_next.ax       = in_reg.ax;
        diff_next.ay       = in_reg.ay;
        diff_next.cx       = in_reg.cx;
        diff_next.cy       = in_reg.cy;
        diff_next.adx      = dx[31] ? dmag_t'(-dx) : dmag_t'(dx);
        diff_next.ady      = dy[31] ? dmag_t'(-dy) : dmag_t'(dy);
        diff_next.sdy      = dx[31] ? -slope_num_t'(dy) : slope_num_t'(dy);
        diff_next.dx_neg   = dx[31];
        diff_next.dx_zero  = (dx == '0);
        diff_next.dy_pos   = !dy[31] && (dy != '0);
        diff_next.dy_neg   = dy[31];
        diff_next.live     = in_reg.anchored && !in_reg.hide;
        diff_next.zero_len = (dx == '0) && (dy == '0);
        diff_next.way      = in_reg.way;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
        end
        else if (diff_ready)
        begin
            diff_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (diff_ready && in_valid_reg)
        begin
            diff_reg <= diff_next;
        end
    end

    // Sector compares against the Q16 borders, then the end or bend point.
    always_comb
    begin
        cmp_t  num;
        cmp_t  lim30;
        cmp_t  lim60;
        dir_t  dir;
        dmag_t mn;
        dmag_t mx;
        logic  x_long;

        num   = cmp_t'(diff_reg.sdy) <<< 16;
        lim30 = cmp_t'(50'(diff_reg.adx) * 50'(TAN30_Q16));
        lim60 = cmp_t'(50'(diff_reg.adx) * 50'(TAN60_Q16));

        dir = DIR_POS_X;
        if (num > lim30)
        begin
            dir = (num > lim60) ? DIR_POS_Y : DIR_POS_XY;
        end
        else if (num < -lim30)
        begin
            dir = (num < -lim60) ? DIR_NEG_Y : DIR_POS_X_NEG;
        end
        // A leftward line turns half way round; the steep case wraps to +y.
        if (diff_reg.dx_neg)
        begin
            dir = dir + DIR_HALF_TURN;
        end
        if (diff_reg.dx_zero)
        begin
            dir = diff_reg.dy_pos ? DIR_POS_Y : DIR_NEG_Y;
        end

        x_long = diff_reg.adx > diff_reg.ady;
        mn     = x_long ? diff_reg.ady : diff_reg.adx;
        mx     = x_long ? diff_reg.adx : diff_reg.ady;

        end_x_next   = '0;
        end_y_next   = '0;
        draw_next    = diff_reg.live;
        changed_next = diff_reg.live && !diff_reg.zero_len;

        if (changed_next)
        begin
            case (route_mode_reg)
                MODE_SNAP:
                begin
                    unique case (dir)
                        DIR_POS_Y:
                        begin
                            end_x_next = diff_reg.ax;
                            end_y_next = coord_step(diff_reg.ay, mx, 1'b0);
                        end
                        DIR_POS_XY:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mn, 1'b0);
                            end_y_next = coord_step(diff_reg.ay, mn, 1'b0);
                        end
                        DIR_POS_X:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mx, 1'b0);
                            end_y_next = diff_reg.ay;
                        end
                        DIR_POS_X_NEG:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mn, 1'b0);
                            end_y_next = coord_step(diff_reg.ay, mn, 1'b1);
                        end
                        DIR_NEG_Y:
                        begin
                            end_x_next = diff_reg.ax;
                            end_y_next = coord_step(diff_reg.ay, mx, 1'b1);
                        end
                        DIR_NEG_XY:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mn, 1'b1);
                            end_y_next = coord_step(diff_reg.ay, mn, 1'b1);
                        end
                        DIR_NEG_X:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mx, 1'b1);
                            end_y_next = diff_reg.ay;
                        end
                        default:
                        begin
                            end_x_next = coord_step(diff_reg.ax, mn, 1'b1);
                            end_y_next = coord_step(diff_reg.ay, mn, 1'b0);
                        end
                    endcase
                end
                MODE_BEND:
                begin
                    // Ties count as y-long.
                    if (!diff_reg.way)
                    begin
                        if (x_long)
                        begin
                            end_x_next = coord_step(diff_reg.cx, diff_reg.ady,
                                                    !diff_reg.dx_neg);
                            end_y_next = diff_reg.ay;
                        end
                        else
                        begin
                            end_x_next = diff_reg.ax;
                            end_y_next = coord_step(diff_reg.cy, diff_reg.adx,
                                                    !diff_reg.dy_neg);
                        end
                    end
                    else
                    begin
                        if (x_long)
                        begin
                            end_x_next = coord_step(diff_reg.ax, diff_reg.ady,
                                                    diff_reg.dx_neg);
                            end_y_next = diff_reg.cy;
                        end
                        else
                        begin
                            end_x_next = diff_reg.cx;
                            end_y_next = coord_step(diff_reg.ay, diff_reg.adx,
                                                    diff_reg.dy_neg);
                        end
                    end
                end
                default:
                begin
                    end_x_next = diff_reg.cx;
                    end_y_next = diff_reg.cy;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= diff_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && diff_valid_reg)
        begin
            end_x_reg   <= end_x_next;
            end_y_reg   <= end_y_next;
            draw_reg    <= draw_next;
            changed_reg <= changed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;
    assign draw      = draw_reg;
    assign changed   = changed_reg;

    // A new point is only reported on a drawn outline.
    a_changed_needs_draw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!changed || draw))
        else $error("changed set without draw");

    // A transaction that is not a new point carries a zero point.
    a_no_point_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !changed) |-> (end_x == '0 && end_y == '0))
        else $error("end point not zero without a change");

    // The input side is held off only when a full pipeline waits on the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && in_valid_reg && diff_valid_reg))
        else $error("input stalled while the pipeline has room");

endmodule
